>>> hw/rtl/qvr_pkg.sv
package qvr_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_QUAT_W = 2'd0;
  localparam logic [1:0] CFG_QUAT_X = 2'd1;
  localparam logic [1:0] CFG_QUAT_Y = 2'd2;
  localparam logic [1:0] CFG_QUAT_Z = 2'd3;

  // Quotient bits resolved by the division pipe, one per stage
  localparam int DIV_STEPS = 32;
  // Stages ahead of the division pipe: products, t sums, partials,
  // full products, numerators, divide prep
  localparam int PRE_STAGES = 6;
  localparam int NUM_STAGES = PRE_STAGES + DIV_STEPS;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               zero_quat;
    logic               clipped;
  } out_t;

endpackage

>>> hw/rtl/quaternion_vector_rotate.sv
// Channel   Ports                          Handshake
// request   start, busy, in_req            taken when start high and busy low
// result    out_valid, out_res             one-cycle strobe, cannot be held off
// config    cfg_we, cfg_idx, cfg_wdata     written when cfg_we high
//
// A request may enter every cycle; busy stays low. Each result passes
// through six multiply and add stages, then the 32-stage restoring
// divider (one quotient bit per stage), then the output register.
// Reset clears the valid chain and loads the quaternion with 1.0.
// A register write reaches the norm squared through the squares and sum registers.
module quaternion_vector_rotate
  import qvr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_req,
  output logic        out_valid,
  output out_t        out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  logic signed [31:0] quat_r [4];
  logic [62:0]        sq_r [4];
  logic [64:0]        den_r;

  logic [NUM_STAGES-1:0] vld_r;

  logic signed [63:0] p_r  [3][4];
  logic signed [65:0] t_r  [4];
  logic signed [64:0] pl_r [4][4];
  logic signed [65:0] ph_r [4][4];
  logic signed [97:0] fp_r [4][4];
  logic signed [97:0] num_r [3];

  logic [64:0] dv_rem_r [DIV_STEPS+1][3];
  logic [31:0] dv_quo_r [DIV_STEPS+1][3];
  logic [31:0] dv_low_r [DIV_STEPS+1][3];
  logic        dv_neg_r [DIV_STEPS+1][3];
  logic        dv_ovf_r [DIV_STEPS+1][3];

  logic        out_vld_r;
  out_t        out_res_r;
  out_t        out_res_nxt;

  logic        accept;
  logic signed [31:0] vin [3];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign vin[0] = in_req.vec_x;
  assign vin[1] = in_req.vec_y;
  assign vin[2] = in_req.vec_z;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r[0] <= 32'sh4000_0000;
      quat_r[1] <= '0;
      quat_r[2] <= '0;
      quat_r[3] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_QUAT_W: quat_r[0] <= cfg_wdata;
        CFG_QUAT_X: quat_r[1] <= cfg_wdata;
        CFG_QUAT_Y: quat_r[2] <= cfg_wdata;
        CFG_QUAT_Z: quat_r[3] <= cfg_wdata;
        default:    quat_r[0] <= quat_r[0];
      endcase
    end
  end

  // Norm squared: squares, then their sum
  always_ff @(posedge clk) begin
    logic signed [63:0] sq;
    for (int j = 0; j < 4; j++) begin
      sq = quat_r[j] * quat_r[j];
      sq_r[j] <= sq[62:0];
    end
    den_r <= 65'(sq_r[0]) + 65'(sq_r[1]) + 65'(sq_r[2]) + 65'(sq_r[3]);
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[NUM_STAGES-2:0], accept};
      out_vld_r <= vld_r[NUM_STAGES-1];
    end
  end

  // Stage 1: vector times quaternion components
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++)
      for (int j = 0; j < 4; j++)
        p_r[c][j] <= vin[c] * quat_r[j];
  end

  // Stage 2: t = (0,v) * conj(q)
  always_ff @(posedge clk) begin
    t_r[0] <= 66'(p_r[0][1]) + 66'(p_r[1][2]) + 66'(p_r[2][3]);
    t_r[1] <= 66'(p_r[0][0]) - 66'(p_r[1][3]) + 66'(p_r[2][2]);
    t_r[2] <= 66'(p_r[1][0]) + 66'(p_r[0][3]) - 66'(p_r[2][1]);
    t_r[3] <= 66'(p_r[1][1]) + 66'(p_r[2][0]) - 66'(p_r[0][2]);
  end

  // Stage 3: split t into low and high halves, multiply each by q
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        pl_r[i][j] <= $signed({1'b0, t_r[i][31:0]}) * quat_r[j];
        ph_r[i][j] <= $signed(t_r[i][65:32]) * quat_r[j];
      end
  end

  // Stage 4: recombine the partial products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        fp_r[i][j] <= $signed({ph_r[i][j], 32'd0}) +
                      $signed({{33{pl_r[i][j][64]}}, pl_r[i][j]});
  end

  // Stage 5: vector part of q * t, indexed [t][q]
  always_ff @(posedge clk) begin
    num_r[0] <= fp_r[1][0] + fp_r[0][1] + fp_r[3][2] - fp_r[2][3];
    num_r[1] <= fp_r[2][0] - fp_r[3][1] + fp_r[0][2] + fp_r[1][3];
    num_r[2] <= fp_r[3][0] + fp_r[2][1] - fp_r[1][2] + fp_r[0][3];
  end

  // Stage 6: take magnitude, flag quotients too large for 32 bits;
  // then the division pipe: one quotient bit per stage
  always_ff @(posedge clk) begin
    logic [97:0] mag;
    logic [65:0] rem2;
    logic [65:0] diff;
    logic        ge;
    for (int c = 0; c < 3; c++) begin
      mag = num_r[c][97] ? 98'(-num_r[c]) : 98'(num_r[c]);
      dv_neg_r[0][c] <= num_r[c][97];
      dv_ovf_r[0][c] <= (mag[96:32] >= den_r);
      dv_rem_r[0][c] <= mag[96:32];
      dv_low_r[0][c] <= mag[31:0];
      dv_quo_r[0][c] <= '0;
    end
    for (int k = 0; k < DIV_STEPS; k++)
      for (int c = 0; c < 3; c++) begin
        rem2 = {dv_rem_r[k][c], dv_low_r[k][c][31]};
        diff = rem2 - {1'b0, den_r};
        ge   = (rem2 >= {1'b0, den_r});
        dv_rem_r[k+1][c] <= ge ? diff[64:0] : rem2[64:0];
        dv_quo_r[k+1][c] <= {dv_quo_r[k][c][30:0], ge};
        dv_low_r[k+1][c] <= {dv_low_r[k][c][30:0], 1'b0};
        dv_neg_r[k+1][c] <= dv_neg_r[k][c];
        dv_ovf_r[k+1][c] <= dv_ovf_r[k][c];
      end
  end

  // Round to nearest, saturate, restore sign; a zero norm forces a zero result
  always_comb begin
    logic [32:0] qf;
    logic [32:0] lim;
    logic [32:0] mag;
    logic        rnd;
    logic        sat;
    logic        clip;
    logic [31:0] res [3];
    clip = 1'b0;
    for (int c = 0; c < 3; c++) begin
      rnd  = ({dv_rem_r[DIV_STEPS][c], 1'b0} >= {1'b0, den_r});
      qf   = {1'b0, dv_quo_r[DIV_STEPS][c]} + 33'(rnd);
      lim  = dv_neg_r[DIV_STEPS][c] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      sat  = dv_ovf_r[DIV_STEPS][c] || (qf > lim);
      mag  = sat ? lim : qf;
      clip = clip | sat;
      res[c] = dv_neg_r[DIV_STEPS][c] ? (32'd0 - mag[31:0]) : mag[31:0];
    end
    if (den_r == '0) begin
      out_res_nxt = '{rot_x: '0, rot_y: '0, rot_z: '0, zero_quat: 1'b1, clipped: 1'b0};
    end else begin
      out_res_nxt = '{rot_x: res[0], rot_y: res[1], rot_z: res[2],
                      zero_quat: 1'b0, clipped: clip};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  // Each result traces back to a start request through the valid chain and output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, NUM_STAGES + 1))
    else $error("result without matching request");

  // Zero quaternion forces zero components and no clip
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.zero_quat) |->
      (out_res.rot_x == 0 && out_res.rot_y == 0 && out_res.rot_z == 0 && !out_res.clipped))
    else $error("zero quaternion result not cleared");

  // A clipped result has at least one component at a rail
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.clipped) |->
      (out_res.rot_x == 32'sh7FFF_FFFF || out_res.rot_x == 32'sh8000_0000 ||
       out_res.rot_y == 32'sh7FFF_FFFF || out_res.rot_y == 32'sh8000_0000 ||
       out_res.rot_z == 32'sh7FFF_FFFF || out_res.rot_z == 32'sh8000_0000))
    else $error("clip flag without saturated component");

endmodule
